### rtl/pte_pkg.sv
// Shared types, constants and helpers for the two-level peak envelope core.
package pte_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int MAG_W        = 17;
  localparam int LEVEL_W      = 8;
  localparam int SPS_W        = 8;
  localparam int SPW_W        = 7;
  localparam int WCOUNT_W     = 6;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int LEVEL_SHIFT  = 7;

  localparam logic [SPS_W-1:0] SPS_RESET = 8'd20;
  localparam logic [SPW_W-1:0] SPW_RESET = 7'd4;
  localparam logic [SPW_W-1:0] SPW_CAP   = 7'd64;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_SLICE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICES_PER_WINDOW = 1'd1;

  localparam logic KIND_FINE   = 1'b0;
  localparam logic KIND_COARSE = 1'b1;

  typedef struct packed {
    logic               dbl;
    logic [LEVEL_W-1:0] fine_level;
    logic [LEVEL_W-1:0] coarse_level;
  } pte_event_t;

  typedef struct packed {
    logic       push;
    pte_event_t ev;
  } pte_push_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    pte_event_t head;
  } pte_qstat_t;

  // max >> 7, saturated (|-32768| gives 255)
  function automatic logic [LEVEL_W-1:0] level_of(input logic [MAG_W-1:0] m);
    logic [LEVEL_W-1:0] l;
    begin
      if (|m[MAG_W-1:LEVEL_SHIFT+LEVEL_W]) begin
        l = '1;
      end else begin
        l = m[LEVEL_SHIFT+LEVEL_W-1:LEVEL_SHIFT];
      end
      return l;
    end
  endfunction

endpackage

### rtl/pte_front.sv
// Front end: config registers, sample magnitude, slice and window peak tracking.
module pte_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pte_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                           q_full,
  output pte_pkg::pte_push_t              q_push
);
  import pte_pkg::*;

  logic [SPS_W-1:0]    sps_cfg_r;
  logic [SPW_W-1:0]    spw_cfg_r;
  logic [SPS_W-1:0]    slice_count_r, slice_count_nxt;
  logic [WCOUNT_W-1:0] wcount_r, wcount_nxt;
  logic [MAG_W-1:0]    slice_max_r, slice_max_nxt;
  logic [MAG_W-1:0]    window_max_r, window_max_nxt;

  logic             accept;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] smax;
  logic [MAG_W-1:0] wmax;
  logic [SPS_W-1:0] sps;
  logic [SPW_W-1:0] spw;
  logic             slice_end;
  logic             win_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign mag  = in_sample[SAMPLE_W-1] ?
                (MAG_W'(1) << SAMPLE_W) - {1'b0, in_sample} : {1'b0, in_sample};
  assign smax = (mag > slice_max_r) ? mag : slice_max_r;
  assign wmax = (smax > window_max_r) ? smax : window_max_r;

  always_comb begin
    sps = (sps_cfg_r == '0) ? SPS_W'(1) : sps_cfg_r;
    if (spw_cfg_r == '0) begin
      spw = SPW_W'(1);
    end else if (spw_cfg_r > SPW_CAP) begin
      spw = SPW_CAP;
    end else begin
      spw = spw_cfg_r;
    end
  end

  assign slice_end = ({1'b0, slice_count_r} + (SPS_W+1)'(1)) >= {1'b0, sps};
  assign win_end   = ({1'b0, wcount_r} + SPW_W'(1)) >= spw;

  always_comb begin
    slice_count_nxt = slice_count_r;
    slice_max_nxt   = slice_max_r;
    wcount_nxt      = wcount_r;
    window_max_nxt  = window_max_r;
    if (accept) begin
      if (!slice_end) begin
        slice_count_nxt = slice_count_r + SPS_W'(1);
        slice_max_nxt   = smax;
      end else begin
        slice_count_nxt = '0;
        slice_max_nxt   = '0;
        if (win_end) begin
          wcount_nxt     = '0;
          window_max_nxt = '0;
        end else begin
          wcount_nxt     = wcount_r + WCOUNT_W'(1);
          window_max_nxt = wmax;
        end
      end
    end
  end

  always_comb begin
    q_push.push            = accept && slice_end;
    q_push.ev.dbl          = win_end;
    q_push.ev.fine_level   = level_of(smax);
    q_push.ev.coarse_level = level_of(wmax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_cfg_r     <= SPS_RESET;
      spw_cfg_r     <= SPW_RESET;
      slice_count_r <= '0;
      wcount_r      <= '0;
      slice_max_r   <= '0;
      window_max_r  <= '0;
    end else begin
      slice_count_r <= slice_count_nxt;
      wcount_r      <= wcount_nxt;
      slice_max_r   <= slice_max_nxt;
      window_max_r  <= window_max_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_SLICE: sps_cfg_r <= cfg_wdata[SPS_W-1:0];
          REG_SLICES_PER_WINDOW: spw_cfg_r <= cfg_wdata[SPW_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/pte_queue.sv
// Small event queue between the front end and the output sequencer.
module pte_queue #(
  parameter int DEPTH = pte_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pte_pkg::pte_push_t   q_push,
  input  logic                 q_pop,
  output pte_pkg::pte_qstat_t  q_stat
);
  import pte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pte_event_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.head  = mem_r[rd_ptr_r];

  assign do_push = q_push.push && !q_stat.full;
  assign do_pop  = q_pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/pte_back.sv
// Output sequencer: turns queued events into fine and coarse envelope requests.
module pte_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pte_pkg::pte_qstat_t          q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [pte_pkg::LEVEL_W-1:0]  out_level,
  output logic                         out_last
);
  import pte_pkg::*;

  logic               phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_last_r;
  logic               load;

  assign load  = !out_valid_r || !out_stall;
  assign q_pop = load && !q_stat.empty && (phase_r || !q_stat.head.dbl);

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        phase_nxt = !phase_r && q_stat.head.dbl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      if (phase_r) begin
        out_kind_r  <= KIND_COARSE;
        out_level_r <= q_stat.head.coarse_level;
        out_last_r  <= 1'b1;
      end else begin
        out_kind_r  <= KIND_FINE;
        out_level_r <= q_stat.head.fine_level;
        out_last_r  <= !q_stat.head.dbl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

endmodule

### rtl/pcm_two_level_peak_envelope_core.sv
// Two-level peak envelope core: one PCM sample in, fine/coarse envelope bytes out.
// Throughput: one sample per cycle while the event queue has room; a window end yields
// two output requests, fine then coarse, each taken only while out_stall is low.
// A slice-ending sample's first request is written to the event queue at its accepting
// edge, then loaded into the output register when that register is empty or being taken.
// Reset (synchronous, rst_n low): counts and maxima clear, samples_per_slice = 20,
// slices_per_window = 4, queue and output register empty.
module pcm_two_level_peak_envelope_core #(
  parameter int QUEUE_DEPTH = pte_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pte_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [pte_pkg::LEVEL_W-1:0]     out_level,
  output logic                            out_last
);
  import pte_pkg::*;

  pte_push_t  q_push;
  pte_qstat_t q_stat;
  logic       q_pop;

  pte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_stat.full),
    .q_push    (q_push)
  );

  pte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_stat (q_stat)
  );

  pte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_level (out_level),
    .out_last  (out_last)
  );

`ifndef NO_ASSERTIONS
  a_coarse_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_COARSE) |-> out_last)
    else $error("coarse request without last");

  a_not_last_is_fine: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_kind == KIND_FINE))
    else $error("non-last request is not fine");

  a_coarse_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (out_valid && out_kind == KIND_COARSE))
    else $error("coarse request did not follow fine request");

  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full)
    else $error("event pushed into full queue");
`endif

endmodule

### bench/pcm_two_level_peak_envelope_core_tb.sv
// Testbench for the two-level peak envelope core: predicted fine and coarse envelope bytes.
`timescale 1ns / 1ps

module pcm_two_level_peak_envelope_core_tb;
  import pte_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } envelope_byte_t;

  localparam int WD_LIMIT    = 5000;
  localparam int PHASE_ITEMS = 105;
  localparam int NUM_PHASES  = 9;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SAMPLES_PER_SLICE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_kind;
  logic [LEVEL_W-1:0]     out_level;
  logic                   out_last;

  // stimulus and prediction
  logic [SAMPLE_W-1:0] sample_fifo[$];
  envelope_byte_t      envelope_q[$];
  logic                in_fire = 1'b0;
  logic                hold = 1'b0;
  int                  in_idle_pct = 0;
  int                  out_idle_pct = 0;
  int                  mismatches = 0;
  int                  wd_count = 0;

  // predictor copy of registers and state
  logic [SPS_W-1:0]    slice_len_reg;
  logic [SPW_W-1:0]    window_len_reg;
  logic [SPS_W-1:0]    slice_cnt;
  logic [WCOUNT_W-1:0] win_slices;
  logic [MAG_W-1:0]    slice_peak;
  logic [MAG_W-1:0]    window_peak;

  pcm_two_level_peak_envelope_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_level (out_level),
    .out_last  (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] peak_to_level(input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] shifted;
    begin
      shifted = mag >> 7;
      return (shifted > 255) ? 8'hFF : shifted[LEVEL_W-1:0];
    end
  endfunction

  task envelope_predict(input logic [SAMPLE_W-1:0] s);
    logic signed [MAG_W-1:0] sx;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        fine;
    int                      slice_len;
    int                      window_len;
    logic                    window_done;
    envelope_byte_t          eb;
    begin
      sx = {s[SAMPLE_W-1], s};
      mag = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
      slice_len = (slice_len_reg == 0) ? 1 : int'(slice_len_reg);
      window_len = (window_len_reg == 0) ? 1 : int'(window_len_reg);
      if (window_len > 64) window_len = 64;
      if (mag > slice_peak) slice_peak = mag;
      if (int'(slice_cnt) + 1 < slice_len) begin
        slice_cnt = slice_cnt + 1'b1;
      end else begin
        fine = slice_peak;
        if (fine > window_peak) window_peak = fine;
        slice_cnt = '0;
        slice_peak = '0;
        window_done = (int'(win_slices) + 1 >= window_len);
        eb.kind = KIND_FINE;
        eb.level = peak_to_level(fine);
        eb.last = !window_done;
        envelope_q.push_back(eb);
        if (!window_done) begin
          win_slices = win_slices + 1'b1;
        end else begin
          eb.kind = KIND_COARSE;
          eb.level = peak_to_level(window_peak);
          eb.last = 1'b1;
          envelope_q.push_back(eb);
          win_slices = '0;
          window_peak = '0;
        end
      end
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (sample_fifo.size() > 0 && !hold && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_sample <= sample_fifo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    envelope_byte_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      slice_len_reg = SPS_RESET;
      window_len_reg = SPW_RESET;
      slice_cnt = '0;
      win_slices = '0;
      slice_peak = '0;
      window_peak = '0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_SLICE: slice_len_reg = cfg_wdata[SPS_W-1:0];
          REG_SLICES_PER_WINDOW: window_len_reg = cfg_wdata[SPW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) envelope_predict(in_sample);
      if (out_valid && !out_stall) begin
        if (envelope_q.size() == 0) begin
          $display("%0t: unexpected request kind=%0d level=%0d last=%0d",
                   $time, out_kind, out_level, out_last);
          mismatches++;
        end else begin
          want = envelope_q.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
            mismatches++;
          end
          if (out_level !== want.level) begin
            $display("%0t: level expected %0d actual %0d", $time, want.level, out_level);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
            mismatches++;
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wd_count <= 0;
    end else if (wd_count >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("pcm_two_level_peak_envelope_core_tb failed");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task wait_idle();
    begin
      do begin
        @(negedge clk);
        #1;
      end while (!(sample_fifo.size() == 0 && !in_valid && envelope_q.size() == 0));
      repeat (6) @(posedge clk);
    end
  endtask

  task set_idle(input int mode);
    begin
      case (mode)
        0: begin in_idle_pct = 29; out_idle_pct = 86; end
        1: begin in_idle_pct = 86; out_idle_pct = 29; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_W'($urandom_range(600)) - 16'd300;
      3: return 16'h7F80 | SAMPLE_W'($urandom_range(127));
      4: return 16'h8000 | SAMPLE_W'($urandom_range(255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] edge_samples[12];
    logic [CFG_DATA_W-1:0] sps_tab[NUM_PHASES];
    logic [CFG_DATA_W-1:0] spw_tab[NUM_PHASES];
    edge_samples = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0080,
                     16'hFF80, 16'h007F, 16'hFF81, 16'h7F80, 16'h7F7F, 16'h8001};
    sps_tab = '{8'd20, 8'd1, 8'd3, 8'd255, 8'd1, 8'd2, 8'd1, 8'd0, 8'd7};
    spw_tab = '{8'd4, 8'd1, 8'd2, 8'd3, 8'd64, 8'd200, 8'd127, 8'd0, 8'd5};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every sample closes a slice and a window
    set_idle(0);
    write_reg(REG_SAMPLES_PER_SLICE, 8'd1);
    write_reg(REG_SLICES_PER_WINDOW, 8'd1);
    foreach (edge_samples[i]) sample_fifo.push_back(edge_samples[i]);
    wait_idle();

    // zero lengths act as one
    write_reg(REG_SAMPLES_PER_SLICE, 8'd0);
    write_reg(REG_SLICES_PER_WINDOW, 8'd0);
    sample_fifo.push_back(16'h8000);
    sample_fifo.push_back(16'h7FFF);
    sample_fifo.push_back(16'h0000);
    wait_idle();

    // shorten slice, then window, while partially filled
    write_reg(REG_SAMPLES_PER_SLICE, 8'd5);
    write_reg(REG_SLICES_PER_WINDOW, 8'd3);
    sample_fifo.push_back(16'h1234);
    sample_fifo.push_back(16'hFC18);
    sample_fifo.push_back(16'h4000);
    wait_idle();
    write_reg(REG_SAMPLES_PER_SLICE, 8'd2);
    sample_fifo.push_back(16'h0100);
    wait_idle();
    write_reg(REG_SLICES_PER_WINDOW, 8'd1);
    sample_fifo.push_back(16'hC000);
    sample_fifo.push_back(16'h0055);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idle(p / 3);
      write_reg(REG_SAMPLES_PER_SLICE, sps_tab[p]);
      write_reg(REG_SLICES_PER_WINDOW, spw_tab[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) sample_fifo.push_back(pick_sample());
      if (p == 1) begin
        do begin
          @(negedge clk);
          #1;
        end while (sample_fifo.size() >= PHASE_ITEMS / 2);
        hold = 1'b1;
        do begin
          @(negedge clk);
          #1;
        end while (in_valid || envelope_q.size() != 0);
        hold = 1'b0;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && envelope_q.size() == 0) begin
      $display("pcm_two_level_peak_envelope_core_tb passed");
    end else begin
      $display("pcm_two_level_peak_envelope_core_tb failed");
    end
    $finish;
  end

endmodule
